/* design/yuv420_alpha_overlay_blend_macros.svh */
// Assertion macros shared by the overlay blend RTL.
`ifndef YUV420_ALPHA_OVERLAY_BLEND_MACROS_SVH
`define YUV420_ALPHA_OVERLAY_BLEND_MACROS_SVH

`ifndef SYNTHESIS
`define YAOB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define YAOB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define YAOB_ASSERT_SAME(label, ante, cons, msg)
`define YAOB_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/yaob_pkg.sv */
// Types, constants and the blend function of the overlay blend block.
package yaob_pkg;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int PAIR_W      = 9;
   localparam int ROW_W       = 12;
   localparam int MAX_HEIGHT  = 4096;
   localparam logic [7:0] FULL_ALPHA = 8'hff;

   typedef enum logic [1:0] {
      REG_REGION_WIDTH  = 2'd0,
      REG_REGION_HEIGHT = 2'd1,
      REG_BLEND_ALPHA   = 2'd2,
      REG_OVERWRITE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] dst_luma;
      logic [7:0] src_luma;
      logic [7:0] src_alpha;
      logic [7:0] dst_alpha;
      logic [7:0] src_cb;
      logic [7:0] src_cr;
      logic [7:0] dst_cb;
      logic [7:0] dst_cr;
   } req_type;

   typedef struct packed {
      logic [7:0] out_luma;
      logic [7:0] out_alpha;
      logic       chroma_valid;
      logic [7:0] out_cb;
      logic [7:0] out_cr;
      logic       region_end;
   } rsp_type;

   typedef struct packed {
      logic [11:0] region_width;
      logic [12:0] region_height;
      logic        blend_with_alpha;
      logic        alpha_replace;
   } cfg_type;

   // what the position stage hands to the blend stage
   typedef struct packed {
      req_type    item;
      logic [7:0] left_alpha;
      logic       quad_done;
      logic       region_end;
   } stage_type;

   function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
      logic [15:0] sum;
      sum = 16'(s) * 16'(a) + 16'(d) * 16'(FULL_ALPHA - a);
      return sum[15:8];
   endfunction

endpackage

/* design/yaob_csr.sv */
// Configuration registers behind the APB-style port.
module yaob_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [yaob_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [yaob_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [yaob_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output yaob_pkg::cfg_type                cfg
);
   import yaob_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_REGION_WIDTH:  cfg_in.region_width     = csr_pwdata[11:0];
            REG_REGION_HEIGHT: cfg_in.region_height    = csr_pwdata[12:0];
            REG_BLEND_ALPHA:   cfg_in.blend_with_alpha = csr_pwdata[0];
            REG_OVERWRITE:     cfg_in.alpha_replace    = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_REGION_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.region_width);
         REG_REGION_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.region_height);
         REG_BLEND_ALPHA:   csr_prdata = CSR_DATA_W'(cfg_ff.blend_with_alpha);
         REG_OVERWRITE:     csr_prdata = CSR_DATA_W'(cfg_ff.alpha_replace);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_width     <= 12'd16;
         cfg_ff.region_height    <= 13'd16;
         cfg_ff.blend_with_alpha <= 1'b1;
         cfg_ff.alpha_replace    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/yaob_walk.sv */
// Raster position counters, alpha pair line buffer and the input register.
`include "yuv420_alpha_overlay_blend_macros.svh"

module yaob_walk #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  yaob_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  yaob_pkg::req_type                 req_data,
   input  logic                              blend_ready,
   output logic                              s1_vld,
   output yaob_pkg::stage_type               s1_data,
   output logic [yaob_pkg::PAIR_W-1:0]       pair_rd
);
   import yaob_pkg::*;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int PAIR_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [7:0]        left_alpha_ff, left_alpha_in;
   logic              s1_vld_ff, s1_vld_in;
   stage_type         s1_data_ff, s1_data_in;
   logic [PAIR_W-1:0] pair_rd_ff;
   logic [PAIR_W-1:0] pair_mem [PAIR_DEPTH];

   logic              s1_en, take, last_col, last_row, pair_wr, pair_re;
   logic [31:0]       width_ext, height_ext;
   logic [COL_W-1:0]  col_last, col_half;
   logic [ROW_W-1:0]  row_last;
   logic [ADDR_W-1:0] slot;
   logic [PAIR_W-1:0] pair_sum;

   assign s1_en     = !s1_vld_ff || blend_ready;
   assign req_stall = !s1_en;
   assign take      = req_valid && s1_en;

   // clamp the region size into range, then compare against the last index
   assign width_ext  = 32'(cfg.region_width);
   assign height_ext = 32'(cfg.region_height);

   always_comb begin
      if (width_ext == 32'd0) begin
         col_last = '0;
      end else if (width_ext > 32'(MAX_WIDTH)) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_W'(width_ext - 32'd1);
      end
      if (height_ext == 32'd0) begin
         row_last = '0;
      end else if (height_ext > 32'(MAX_HEIGHT)) begin
         row_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_W'(height_ext - 32'd1);
      end
   end

   assign last_col = col_ff >= col_last;
   assign last_row = row_ff >= row_last;
   assign col_half = col_ff >> 1;
   assign slot     = col_half[ADDR_W-1:0];
   assign pair_sum = PAIR_W'(left_alpha_ff) + PAIR_W'(req_data.src_alpha);
   // even rows store the pair sums, odd rows read them back
   assign pair_wr  = take && col_ff[0] && !row_ff[0];
   assign pair_re  = take && col_ff[0] && row_ff[0];

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      left_alpha_in = left_alpha_ff;
      if (take) begin
         if (!col_ff[0]) begin
            left_alpha_in = req_data.src_alpha;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_vld_in  = s1_en ? req_valid : s1_vld_ff;
      s1_data_in = s1_data_ff;
      if (take) begin
         s1_data_in.item       = req_data;
         s1_data_in.left_alpha = left_alpha_ff;
         s1_data_in.quad_done  = col_ff[0] && row_ff[0];
         s1_data_in.region_end = last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         left_alpha_ff <= '0;
         s1_vld_ff     <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_alpha_ff <= left_alpha_in;
         s1_vld_ff     <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
   end

   always_ff @(posedge clock) begin
      if (pair_wr) begin
         pair_mem[slot] <= pair_sum;
      end
      if (pair_re) begin
         pair_rd_ff <= pair_mem[slot];
      end
   end

   assign s1_vld  = s1_vld_ff;
   assign s1_data = s1_data_ff;
   assign pair_rd = pair_rd_ff;

   `YAOB_ASSERT_NEXT(a_region_wrap, take && last_col && last_row, col_ff == '0 && row_ff == '0, "counters did not wrap at region end")
   `YAOB_ASSERT_NEXT(a_s1_hold, s1_vld_ff && !blend_ready, s1_vld_ff, "stage item dropped while blend stage full")
   `YAOB_ASSERT_SAME(a_no_rw_mix, take, !(pair_wr && pair_re), "line buffer read and written by one item")

endmodule

/* design/yaob_mix.sv */
// Luma, alpha and chroma blend feeding the result register.
`include "yuv420_alpha_overlay_blend_macros.svh"

module yaob_mix (
   input  logic                         clock,
   input  logic                         reset,
   input  yaob_pkg::cfg_type            cfg,
   input  logic                         s1_vld,
   input  yaob_pkg::stage_type          s1_data,
   input  logic [yaob_pkg::PAIR_W-1:0]  pair_rd,
   output logic                         blend_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output yaob_pkg::rsp_type            rsp_data
);
   import yaob_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [9:0] quad_sum;
   logic [7:0] avg_alpha;
   rsp_type    result;

   assign blend_ready = !rsp_valid_ff || !rsp_stall;

   // mean of the four source alphas: stored upper pair plus the lower pair
   assign quad_sum  = 10'(pair_rd) + 10'(s1_data.left_alpha) + 10'(s1_data.item.src_alpha);
   assign avg_alpha = quad_sum[9:2];

   always_comb begin
      result              = '0;
      result.region_end   = s1_data.region_end;
      result.chroma_valid = s1_data.quad_done;
      if (cfg.blend_with_alpha) begin
         result.out_luma  = mix8(s1_data.item.src_luma, s1_data.item.dst_luma,
                                 s1_data.item.src_alpha);
         result.out_alpha = cfg.alpha_replace ? s1_data.item.src_alpha
                                              : s1_data.item.dst_alpha;
      end else begin
         result.out_luma  = s1_data.item.src_luma;
         result.out_alpha = s1_data.item.dst_alpha;
      end
      if (s1_data.quad_done) begin
         if (cfg.blend_with_alpha) begin
            result.out_cb = mix8(s1_data.item.src_cb, s1_data.item.dst_cb, avg_alpha);
            result.out_cr = mix8(s1_data.item.src_cr, s1_data.item.dst_cr, avg_alpha);
         end else begin
            result.out_cb = s1_data.item.src_cb;
            result.out_cr = s1_data.item.src_cr;
         end
      end
   end

   always_comb begin
      rsp_valid_in = blend_ready ? s1_vld : rsp_valid_ff;
      rsp_data_in  = (blend_ready && s1_vld) ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `YAOB_ASSERT_NEXT(a_move_on, s1_vld && blend_ready, rsp_valid_ff, "stage item not moved to result")
   `YAOB_ASSERT_SAME(a_chroma_zero, rsp_valid_ff && !rsp_data_ff.chroma_valid, rsp_data_ff.out_cb == 8'd0 && rsp_data_ff.out_cr == 8'd0, "chroma without a finished quad")

endmodule

/* design/yuv420_alpha_overlay_blend.sv */
// Top level of the YUV 4:2:0 overlay alpha blend.
//
//   port group | dir | handshake             | contents
//   req_*      | in  | req_valid / req_stall  | one pixel: luma, alpha, quad chroma
//   rsp_*      | out | rsp_valid / rsp_stall  | blended pixel, chroma on quad end
//   csr_*      | in  | psel/penable, pready=1 | region size and blend mode
//
// One pixel per clock while req_stall is low; an accepted item goes through the input
// register (with the line buffer read), then the blend into the result register, which
// raises rsp_valid.
// The alpha pair line buffer takes one write or one read per odd-column pixel, none on even columns.
// Reset is synchronous; the line buffer is not cleared and is filled by even rows.
// req_stall rises only when both the stage register and a stalled result are full.
module yuv420_alpha_overlay_blend #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  yaob_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output yaob_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [yaob_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [yaob_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [yaob_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import yaob_pkg::*;

   cfg_type           cfg;
   logic              s1_vld, blend_ready;
   stage_type         s1_data;
   logic [PAIR_W-1:0] pair_rd;

   yaob_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   yaob_walk #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .blend_ready (blend_ready),
      .s1_vld      (s1_vld),
      .s1_data     (s1_data),
      .pair_rd     (pair_rd)
   );

   yaob_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .s1_vld      (s1_vld),
      .s1_data     (s1_data),
      .pair_rd     (pair_rd),
      .blend_ready (blend_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* tb/yuv420_alpha_overlay_blend_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the YUV 4:2:0 overlay alpha blend block.
module yuv420_alpha_overlay_blend_tb;
   import yaob_pkg::*;

   localparam int REGION_MAX_W  = 2048;
   localparam int PAIR_SLOTS    = REGION_MAX_W / 2;
   localparam int RANDOM_PIXELS = 1650;
   localparam int CYCLE_LIMIT   = 600000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register mirror and blend state of the predictor
   cfg_type    cfg = '{region_width: 12'd16, region_height: 13'd16,
                       blend_with_alpha: 1'b1, alpha_replace: 1'b1};
   int         col_pos = 0;
   int         row_pos = 0;
   logic [7:0] left_alpha_hold = '0;
   logic [8:0] pair_sum [PAIR_SLOTS];

   req_type        pending_px [$];
   rsp_type        blended_q [$];
   int             px_queued = 0;
   int             rsp_seen = 0;
   int             random_px = 0;
   int             cycle_count = 0;
   bit             px_taken = 1'b0;
   bit             mismatch_seen = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   stall_kind_type stall_mode = STALL_NONE;
   int             stall_span = 0;

   yuv420_alpha_overlay_blend #(.MAX_WIDTH(REGION_MAX_W)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] weigh(input logic [7:0] s, input logic [7:0] d,
                                        input logic [7:0] a);
      logic [15:0] acc;
      acc = s * a + d * (FULL_ALPHA - a);
      return acc[15:8];
   endfunction

   function automatic int clamp_width();
      int w;
      w = cfg.region_width;
      if (w == 0) w = 1;
      if (w > REGION_MAX_W) w = REGION_MAX_W;
      return w;
   endfunction

   function automatic int clamp_height();
      int h;
      h = cfg.region_height;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   // blended pixel for one accepted item; advances the raster position
   function automatic rsp_type blend_pixel(input req_type px);
      rsp_type r;
      int      slot;
      int      avg;
      bit      last_col;
      bit      last_row;
      r = '0;
      if (cfg.blend_with_alpha) begin
         r.out_luma  = weigh(px.src_luma, px.dst_luma, px.src_alpha);
         r.out_alpha = cfg.alpha_replace ? px.src_alpha : px.dst_alpha;
      end else begin
         r.out_luma  = px.src_luma;
         r.out_alpha = px.dst_alpha;
      end
      slot = (col_pos >> 1) % PAIR_SLOTS;
      if (col_pos % 2 == 0) begin
         left_alpha_hold = px.src_alpha;
      end else if (row_pos % 2 == 0) begin
         pair_sum[slot] = left_alpha_hold + px.src_alpha;
      end else begin
         // lower right pixel closes the quad
         avg = (int'(pair_sum[slot]) + int'(left_alpha_hold) + int'(px.src_alpha)) >> 2;
         r.chroma_valid = 1'b1;
         if (cfg.blend_with_alpha) begin
            r.out_cb = weigh(px.src_cb, px.dst_cb, 8'(avg));
            r.out_cr = weigh(px.src_cr, px.dst_cr, 8'(avg));
         end else begin
            r.out_cb = px.src_cb;
            r.out_cr = px.src_cr;
         end
      end
      last_col = col_pos >= clamp_width() - 1;
      last_row = row_pos >= clamp_height() - 1;
      r.region_end = last_col && last_row;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatch_seen = 1'b1;
      end
   endtask

   // accept side and result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         blended_q.push_back(blend_pixel(req_data));
         px_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (blended_q.size() == 0) begin
            $display("%0t: result with none pending, got %p", $time, rsp_data);
            mismatch_seen = 1'b1;
         end else begin
            want = blended_q.pop_front();
            compare_field("out_luma", want.out_luma, rsp_data.out_luma);
            compare_field("out_alpha", want.out_alpha, rsp_data.out_alpha);
            compare_field("chroma_valid", want.chroma_valid, rsp_data.chroma_valid);
            compare_field("out_cb", want.out_cb, rsp_data.out_cb);
            compare_field("out_cr", want.out_cr, rsp_data.out_cr);
            compare_field("region_end", want.region_end, rsp_data.region_end);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d results seen", $time, rsp_seen, px_queued);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // pixel sender: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || px_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_px.size() > 0) begin
            req_data  <= pending_px.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      px_taken = 1'b0;
   end

   // result stall pattern, switched between modes now and then
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 3));
         stall_span = $urandom_range(20, 200);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
         default:        rsp_stall <= (stall_span % 8 < 5);
      endcase
   end

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] stored;
      case (idx)
         REG_REGION_WIDTH:  stored = value & 32'hfff;
         REG_REGION_HEIGHT: stored = value & 32'h1fff;
         default:           stored = value & 32'h1;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_REGION_WIDTH:  cfg.region_width     = stored[11:0];
         REG_REGION_HEIGHT: cfg.region_height    = stored[12:0];
         REG_BLEND_ALPHA:   cfg.blend_with_alpha = stored[0];
         default:           cfg.alpha_replace    = stored[0];
      endcase
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         $display("%0t: register %s read expected %0d got %0d",
                  $time, idx.name(), stored, csr_prdata);
         mismatch_seen = 1'b1;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (rsp_seen != px_queued) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_px(input req_type px);
      pending_px.push_back(px);
      px_queued++;
   endtask

   task automatic send_random(input int count);
      req_type px;
      repeat (count) begin
         px = req_type'({$urandom, $urandom});
         // lean on the alpha extremes now and then
         case ($urandom_range(0, 7))
            0:       px.src_alpha = 8'h00;
            1:       px.src_alpha = 8'hff;
            default: ;
         endcase
         send_px(px);
      end
   endtask

   task automatic setup_region(input int w, input int h, input bit blend, input bit ow);
      wait_drained();
      csr_write(REG_REGION_WIDTH, w);
      csr_write(REG_REGION_HEIGHT, h);
      csr_write(REG_BLEND_ALPHA, blend);
      csr_write(REG_OVERWRITE, ow);
   endtask

   initial begin
      int w;
      int h;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one quad, full and empty alpha, blend with alpha overwrite
      setup_region(2, 2, 1'b1, 1'b1);
      send_px('{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
      send_px('{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
      send_px('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0});
      send_px('{8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255});
      // opaque quad, destination alpha kept
      setup_region(2, 2, 1'b1, 1'b0);
      repeat (3) send_px('{8'd17, 8'd200, 8'd255, 8'd99, 8'd1, 8'd2, 8'd3, 8'd4});
      send_px('{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255});
      // plain copy
      setup_region(2, 2, 1'b0, 1'b1);
      send_px('{8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0});
      send_px('{8'd0, 8'd255, 8'd127, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0});
      send_px('{8'd128, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
      send_px('{8'd1, 8'd254, 8'd255, 8'd255, 8'd255, 8'd254, 8'd1, 8'd0});
      // odd width and height: last column and row have no partner
      setup_region(3, 3, 1'b1, 1'b1);
      send_random(9);

      // zero width and zero height act as one
      setup_region(0, 3, 1'b1, 1'b0);
      send_random(3);
      setup_region(3, 0, 1'b0, 1'b1);
      send_random(3);
      // oversized height, then cut short from inside the region
      setup_region(2, 8191, 1'b1, 1'b1);
      send_random(8);
      wait_drained();
      csr_write(REG_REGION_HEIGHT, 1);
      send_random(2);

      while (random_px < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       w = 1;
            1:       w = 2;
            7:       w = $urandom_range(25, 80);
            8:       w = $urandom_range(81, 200);
            9:       w = 2 * $urandom_range(1, 8);
            default: w = $urandom_range(2, 24);
         endcase
         h = (w > 80) ? $urandom_range(1, 3) : $urandom_range(1, 8);
         setup_region(w, h, $urandom_range(0, 3) != 0, $urandom_range(0, 1));
         repeat ($urandom_range(1, 2)) begin
            send_random(clamp_width() * clamp_height());
            random_px += clamp_width() * clamp_height();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (!mismatch_seen && blended_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
